// ===== rtl/ehgc_pkg.sv =====
// ----------------------------------------------------------------------------
// ehgc_pkg
// Shared types and constants for the entropy health / GHASH conditioner.
// ----------------------------------------------------------------------------
package ehgc_pkg;

   localparam logic [2:0] STATUS_ABSORBED = 3'd0;
   localparam logic [2:0] STATUS_EMITTED  = 3'd1;
   localparam logic [2:0] STATUS_REP_FAIL = 3'd2;
   localparam logic [2:0] STATUS_APT_FAIL = 3'd3;
   localparam logic [2:0] STATUS_REJECTED = 3'd4;

   localparam logic [7:0] POLY_LOW = 8'h87;
   localparam int unsigned MUL_DIGIT = 8;
   localparam int unsigned MUL_STEPS = 128 / MUL_DIGIT;

   localparam logic [2:0] REG_KEY_LOW  = 3'd0;
   localparam logic [2:0] REG_KEY_HIGH = 3'd1;
   localparam logic [2:0] REG_SEED_LOW = 3'd2;
   localparam logic [2:0] REG_SEED_HIGH = 3'd3;
   localparam logic [2:0] REG_REP_CUT  = 3'd4;
   localparam logic [2:0] REG_APT_CUT  = 3'd5;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture sample, xor into accumulator operand
      logic step;      // one multiply digit
      logic commit;    // write product back to accumulator
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_step;
   } dp_status_type;

endpackage

// ===== rtl/ehgc_stream_if.sv =====
// ----------------------------------------------------------------------------
// ehgc_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface ehgc_stream_if #(parameter int unsigned WIDTH = 128);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ehgc_datapath.sv =====
// ----------------------------------------------------------------------------
// ehgc_datapath
// Accumulator and digit-serial GF(2^128) multiplier, 8 accumulator-operand bits/cycle.
// ----------------------------------------------------------------------------
module ehgc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ehgc_pkg::dp_cmd_type   cmd,
   output ehgc_pkg::dp_status_type stat,
   input  logic [127:0]           sample,
   input  logic [127:0]           key,
   input  logic                   seed_lo_we,
   input  logic                   seed_hi_we,
   input  logic [63:0]            seed_data,
   output logic [127:0]           acc
);
   import ehgc_pkg::*;

   logic [127:0] acc_ff, acc_in;
   logic [127:0] opa_ff, opa_in;
   logic [127:0] z_ff, z_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic [127:0] z_step;

   // Horner over one digit: z = z*x ^ (bit? key) for 8 bits, msb first.
   always_comb begin
      logic [127:0] z;
      z = z_ff;
      for (int b = MUL_DIGIT - 1; b >= 0; b--) begin
         z = {z[126:0], 1'b0} ^ (z[127] ? {120'd0, POLY_LOW} : 128'd0);
         if (opa_ff[120 + b]) z = z ^ key;
      end
      z_step = z;
   end

   always_comb begin
      acc_in = acc_ff;
      opa_in = opa_ff;
      z_in   = z_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         opa_in = acc_ff ^ sample;
         z_in   = '0;
         cnt_in = '0;
      end else if (cmd.step) begin
         z_in   = z_step;
         opa_in = {opa_ff[119:0], 8'd0};
         cnt_in = cnt_ff + 4'd1;
      end
      if (cmd.commit) acc_in = z_ff;
      if (seed_lo_we) acc_in[63:0]   = seed_data;
      if (seed_hi_we) acc_in[127:64] = seed_data;
   end

   always_ff @(posedge clock) begin
      opa_ff <= opa_in;
      z_ff   <= z_in;
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign stat.last_step = (cnt_ff == 4'(MUL_STEPS - 1));
   assign acc = acc_ff;
endmodule

// ===== rtl/ehgc_controller.sv =====
// ----------------------------------------------------------------------------
// ehgc_controller
// Health tests, sequencing of the multiplier and the result register.
// ----------------------------------------------------------------------------
module ehgc_controller #(
   parameter int unsigned WINDOW_SIZE = 512,
   parameter int unsigned EMIT_RATIO  = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              health_byte,
   input  logic [7:0]              rep_cut,
   input  logic [9:0]              apt_cut,
   output ehgc_pkg::dp_cmd_type    cmd,
   input  ehgc_pkg::dp_status_type stat,
   input  logic [127:0]            acc,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [127:0]            rsp_block
);
   import ehgc_pkg::*;

   localparam int unsigned PW = $clog2(WINDOW_SIZE);
   localparam int unsigned EW = (EMIT_RATIO > 1) ? $clog2(EMIT_RATIO) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [7:0]    last_ff, last_in, run_ff, run_in, ref_ff, ref_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [9:0]    match_ff, match_in;
   logic          fail_ff, fail_in;
   logic [EW-1:0] pass_ff, pass_in;
   logic          ovld_ff, ovld_in;
   logic [2:0]    ost_ff, ost_in;
   logic [127:0]  oblk_ff, oblk_in;
   logic          post_ff;
   logic          out_free, acc_take;

   // no new request while the result of the last pass is being loaded
   assign out_free  = !ovld_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free && !post_ff;
   assign acc_take  = req_valid && req_ready;

   always_comb begin
      logic [2:0] r;
      state_in = state_ff;
      last_in = last_ff; run_in = run_ff; ref_in = ref_ff;
      pos_in = pos_ff; match_in = match_ff; fail_in = fail_ff;
      pass_in = pass_ff;
      ovld_in = ovld_ff && !rsp_ready;
      ost_in = ost_ff; oblk_in = oblk_ff;
      cmd = '0;
      r = STATUS_ABSORBED;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc_take) begin
               if (fail_ff) begin
                  r = STATUS_REJECTED;
               end else begin
                  // repetition count test
                  if (health_byte == last_ff) begin
                     if (run_ff != 8'hff) run_in = run_ff + 8'd1;
                     if (run_in >= rep_cut) r = STATUS_REP_FAIL;
                  end else begin
                     last_in = health_byte;
                     run_in  = 8'd1;
                  end
                  // adaptive proportion test
                  if (r == STATUS_ABSORBED) begin
                     if (pos_ff == '0) begin
                        ref_in   = health_byte;
                        match_in = 10'd1;
                     end else if (health_byte == ref_ff) begin
                        if (match_ff != 10'h3ff) match_in = match_ff + 10'd1;
                        if (match_in >= apt_cut) r = STATUS_APT_FAIL;
                     end
                     if (r == STATUS_ABSORBED)
                        pos_in = (pos_ff == PW'(WINDOW_SIZE - 1)) ? '0 : pos_ff + 1'b1;
                  end
               end
               if (r == STATUS_ABSORBED) begin
                  cmd.load = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  if (r != STATUS_REJECTED) fail_in = 1'b1;
                  ovld_in = 1'b1;
                  ost_in  = r;
                  oblk_in = '0;
               end
            end
         end
         ST_MUL: begin
            cmd.step = 1'b1;
            if (stat.last_step) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // result written the cycle after commit (acc then holds the product)
      if (post_ff) begin
         ovld_in = 1'b1;
         if (pass_ff == EW'(EMIT_RATIO - 1) || EMIT_RATIO == 1) begin
            pass_in = '0;
            ost_in  = STATUS_EMITTED;
            oblk_in = acc;
         end else begin
            pass_in = pass_ff + 1'b1;
            ost_in  = STATUS_ABSORBED;
            oblk_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ost_ff  <= ost_in;
      oblk_ff <= oblk_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff <= '0; run_ff <= '0; ref_ff <= '0;
         pos_ff <= '0; match_ff <= '0; fail_ff <= 1'b0;
         pass_ff <= '0; ovld_ff <= 1'b0; post_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in; run_ff <= run_in; ref_ff <= ref_in;
         pos_ff <= pos_in; match_ff <= match_in; fail_ff <= fail_in;
         pass_ff <= pass_in; ovld_ff <= ovld_in;
         post_ff <= (state_ff == ST_DONE);
      end
   end

   assign rsp_valid  = ovld_ff;
   assign rsp_status = ost_ff;
   assign rsp_block  = oblk_ff;
endmodule

// ===== rtl/entropy_health_ghash_conditioner.sv =====
// ----------------------------------------------------------------------------
// entropy_health_ghash_conditioner
// Health-tested noise conditioner with a GF(2^128) hash accumulator.
// ----------------------------------------------------------------------------
// Each request is a 128-bit raw sample; its low byte runs a repetition count
// test and an adaptive proportion test over WINDOW_SIZE bytes. Any failure
// latches and later requests answer "rejected". A passing sample is XORed
// into the accumulator and multiplied by key H modulo x^128+x^7+x^2+x+1, and
// every EMIT_RATIO-th pass returns the block. A rejected or failing request
// is answered straight from idle; a passing one runs through accept, 16
// multiplier digits of 8 accumulator-operand bits, commit and result load
// before the next request. One result stage decouples the response side. CSR
// writes only while idle; seed writes reload that half of the accumulator.
module entropy_health_ghash_conditioner #(
   parameter int unsigned WINDOW_SIZE = 512,
   parameter int unsigned EMIT_RATIO  = 8
) (
   input  logic        clock,
   input  logic        reset,
   ehgc_stream_if.sink   req,
   ehgc_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import ehgc_pkg::*;

   // request payload {sample_high, sample_low}; response {status, high, low}
   logic [63:0] key_lo_ff, key_hi_ff, seed_lo_ff, seed_hi_ff;
   logic [7:0]  rep_cut_ff;
   logic [9:0]  apt_cut_ff;
   logic        wr;
   logic [2:0]  idx;
   logic [127:0] acc, blk;
   logic [2:0]  st;
   dp_cmd_type    cmd;
   dp_status_type stat;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_lo_ff <= '0; key_hi_ff <= '0; seed_lo_ff <= '0; seed_hi_ff <= '0;
         rep_cut_ff <= 8'd21; apt_cut_ff <= 10'd410;
      end else if (wr) begin
         unique case (idx)
            REG_KEY_LOW:   key_lo_ff  <= csr_pwdata;
            REG_KEY_HIGH:  key_hi_ff  <= csr_pwdata;
            REG_SEED_LOW:  seed_lo_ff <= csr_pwdata;
            REG_SEED_HIGH: seed_hi_ff <= csr_pwdata;
            REG_REP_CUT:   rep_cut_ff <= csr_pwdata[7:0];
            REG_APT_CUT:   apt_cut_ff <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_KEY_LOW:   csr_prdata = key_lo_ff;
         REG_KEY_HIGH:  csr_prdata = key_hi_ff;
         REG_SEED_LOW:  csr_prdata = seed_lo_ff;
         REG_SEED_HIGH: csr_prdata = seed_hi_ff;
         REG_REP_CUT:   csr_prdata = {56'd0, rep_cut_ff};
         REG_APT_CUT:   csr_prdata = {54'd0, apt_cut_ff};
         default:       csr_prdata = '0;
      endcase
   end

   ehgc_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .sample     (req.data),
      .key        ({key_hi_ff, key_lo_ff}),
      .seed_lo_we (wr && idx == REG_SEED_LOW),
      .seed_hi_we (wr && idx == REG_SEED_HIGH),
      .seed_data  (csr_pwdata),
      .acc
   );

   ehgc_controller #(.WINDOW_SIZE(WINDOW_SIZE), .EMIT_RATIO(EMIT_RATIO)) u_ctl (
      .clock, .reset,
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .health_byte (req.data[7:0]),
      .rep_cut     (rep_cut_ff),
      .apt_cut     (apt_cut_ff),
      .cmd, .stat, .acc,
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .rsp_status  (st),
      .rsp_block   (blk)
   );

   assign rsp.data = {st, blk};
endmodule

// ===== tb/sv/tb_entropy_health_ghash_conditioner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_entropy_health_ghash_conditioner
// Self-checking bench for the health-gated GF(2^128) noise conditioner.
// ----------------------------------------------------------------------------
// Raw samples are pushed through the request channel while a local model
// runs the repetition and proportion tests and the hash update. Each
// response is checked against the oldest prediction. Keys, seeds and
// cutoffs change between phases while the block is idle. Backpressure and
// source gaps vary by phase. A health failure latches until reset, so it is
// forced only once, at the very end, and the rejected responses after it
// are checked too.
// ----------------------------------------------------------------------------
module tb_entropy_health_ghash_conditioner;
   import ehgc_pkg::*;

   localparam int RSP_W      = 131;   // {status, block_high, block_low}
   localparam int WINDOW     = 512;
   localparam int EMIT_EVERY = 8;
   localparam int DRAIN_WAIT = 40;    // exceeds a full multiplier pass plus result stage

   typedef struct packed {
      logic [2:0]   status;
      logic [63:0]  block_high;
      logic [63:0]  block_low;
   } conditioner_result_t;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   ehgc_stream_if #(.WIDTH(128))   req_ch ();
   ehgc_stream_if #(.WIDTH(RSP_W)) rsp_ch ();

   entropy_health_ghash_conditioner dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch.sink),
      .rsp         (rsp_ch.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------
   // Local copy of the conditioner: configuration and health/hash state
   // ---------------------------------------------------------------------
   logic [127:0] hash_key;
   logic [127:0] accum;
   logic [7:0]   rep_cut;
   logic [9:0]   apt_cut;
   logic [7:0]   prev_byte;
   logic [7:0]   run_len;
   logic [7:0]   win_ref;
   logic [8:0]   win_pos;
   logic [9:0]   win_hits;
   logic         latched_fail;
   logic [2:0]   passes;

   conditioner_result_t expected_results[$];

   int error_count;
   int sent_count;
   int emit_count;
   int reject_count;
   int send_idle_pct;
   int recv_stall_pct;

   // GF(2^128) product, bit i = x^i, reduced by x^128 + x^7 + x^2 + x + 1
   function automatic logic [127:0] gf128_product(input logic [127:0] a,
                                                  input logic [127:0] b);
      logic [127:0] z;
      logic         carry;
      z = '0;
      for (int i = 127; i >= 0; i--) begin
         carry = z[127];
         z = z << 1;
         if (carry) begin
            z[7:0] = z[7:0] ^ POLY_LOW;
         end
         if (a[i]) begin
            z = z ^ b;
         end
      end
      return z;
   endfunction

   // Repetition count then adaptive proportion; returns absorbed or a fail code
   function automatic logic [2:0] health_verdict(input logic [7:0] b);
      if (b == prev_byte) begin
         if (run_len != 8'hFF) begin
            run_len = run_len + 8'd1;
         end
         if (run_len >= rep_cut) begin
            return STATUS_REP_FAIL;
         end
      end else begin
         prev_byte = b;
         run_len   = 8'd1;
      end
      if (win_pos == 9'd0) begin
         win_ref  = b;
         win_hits = 10'd1;
      end else if (b == win_ref) begin
         if (win_hits != 10'h3FF) begin
            win_hits = win_hits + 10'd1;
         end
         if (win_hits >= apt_cut) begin
            return STATUS_APT_FAIL;
         end
      end
      win_pos = (int'(win_pos) + 1 >= WINDOW) ? 9'd0 : win_pos + 9'd1;
      return STATUS_ABSORBED;
   endfunction

   function automatic conditioner_result_t condition_sample(input logic [127:0] s);
      conditioner_result_t r;
      logic [2:0]          v;
      r = '0;
      if (latched_fail) begin
         r.status = STATUS_REJECTED;
         return r;
      end
      v = health_verdict(s[7:0]);
      if (v != STATUS_ABSORBED) begin
         latched_fail = 1'b1;
         r.status = v;
         return r;
      end
      accum  = gf128_product(accum ^ s, hash_key);
      passes = passes + 3'd1;
      if (int'(passes) % EMIT_EVERY == 0) begin
         passes       = 3'd0;
         r.status     = STATUS_EMITTED;
         r.block_low  = accum[63:0];
         r.block_high = accum[127:64];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Shared tasks
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
   endtask

   // APB write: setup then access, register taken at the access edge
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_KEY_LOW:   hash_key[63:0]   = value;
         REG_KEY_HIGH:  hash_key[127:64] = value;
         REG_SEED_LOW:  accum[63:0]      = value;
         REG_SEED_HIGH: accum[127:64]    = value;
         REG_REP_CUT:   rep_cut          = value[7:0];
         REG_APT_CUT:   apt_cut          = value[9:0];
         default: ;
      endcase
   endtask

   // stop the source, then let every outstanding request drain
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // one request; prediction is made on the accepting edge
   task automatic send_sample(input logic [63:0] lo, input logic [63:0] hi);
      int gap;
      gap = (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) ?
            $urandom_range(6, 1) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.data  <= {hi, lo};
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      expected_results.push_back(condition_sample({hi, lo}));
      sent_count++;
   endtask

   task automatic end_stream();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // health byte: mostly fresh, sometimes repeating the previous one
   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      if ($urandom_range(99) < 20) begin
         return prev_byte;
      end
      b = 8'($urandom);
      return b;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random stalls at the falling edge, checks at the rising
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      conditioner_result_t got;
      conditioner_result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", 64'(got.status), 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (got.status != want.status)
               report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.block_low != want.block_low)
               report_mismatch("block_low", got.block_low, want.block_low);
            if (got.block_high != want.block_high)
               report_mismatch("block_high", got.block_high, want.block_high);
            if (want.status == STATUS_EMITTED) emit_count++;
            if (want.status == STATUS_REJECTED) reject_count++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // reset values: zero key and seed, first byte zero joins the empty run
   task automatic test_after_reset();
      send_sample(64'h0, 64'h0);
      send_sample(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      for (int i = 0; i < 6; i++) send_sample({rand64()} , rand64());
      wait_idle();
   endtask

   // every register written, key extremes, emission of known blocks
   task automatic test_key_extremes();
      csr_write(REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_SEED_LOW, 64'h0);
      csr_write(REG_SEED_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_REP_CUT, 64'd255);
      csr_write(REG_APT_CUT, 64'd512);
      for (int i = 0; i < 8; i++) send_sample({56'h0, 8'(i + 1)}, 64'h0);
      wait_idle();
      // identity key x^0; a short repeated run stays below the cutoff
      csr_write(REG_KEY_LOW, 64'h1);
      csr_write(REG_KEY_HIGH, 64'h0);
      for (int i = 0; i < 8; i++) send_sample({56'hFFFF_FFFF_FFFF_FF, 8'hA5}, rand64());
      wait_idle();
   endtask

   // several settings, each under a different idling pattern
   task automatic test_random_traffic();
      int rep_opts[4] = '{255, 21, 10, 40};
      int apt_opts[4] = '{512, 410, 60, 300};
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(REG_KEY_LOW, rand64());
         csr_write(REG_KEY_HIGH, rand64());
         csr_write(REG_SEED_LOW, rand64());
         csr_write(REG_SEED_HIGH, rand64());
         csr_write(REG_REP_CUT, 64'(rep_opts[ph]));
         csr_write(REG_APT_CUT, 64'(apt_opts[ph]));
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         for (int i = 0; i < 125; i++) begin
            send_sample({rand64()} & 64'hFFFF_FFFF_FFFF_FF00 | 64'(pick_byte()),
                        rand64());
         end
         wait_idle();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // force one latching failure, chosen at random, then check rejection
   task automatic test_health_failure();
      logic [7:0] b;
      b = 8'($urandom);
      if ($urandom_range(1) == 0) begin
         csr_write(REG_REP_CUT, 64'd2);
         send_sample({56'h0, b + 8'd1}, rand64());
         send_sample({56'h0, b}, rand64());
         send_sample({56'h0, b}, rand64());   // run of two trips the cutoff
      end else begin
         csr_write(REG_REP_CUT, 64'd255);
         csr_write(REG_APT_CUT, 64'd2);
         // the reference byte reappearing inside its window trips the cutoff
         for (int i = 0; i < 3 && !latched_fail; i++) begin
            send_sample({56'h0, win_ref}, rand64());
         end
      end
      send_idle_pct  = 30;
      recv_stall_pct = 30;
      for (int i = 0; i < 12; i++) send_sample(rand64(), rand64());
      end_stream();
      wait_idle();
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.data    = '0;
      rsp_ch.ready   = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      error_count    = 0;
      sent_count     = 0;
      emit_count     = 0;
      reject_count   = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hash_key       = '0;
      accum          = '0;
      rep_cut        = 8'd21;
      apt_cut        = 10'd410;
      prev_byte      = '0;
      run_len        = '0;
      win_ref        = '0;
      win_pos        = '0;
      win_hits       = '0;
      latched_fail   = 1'b0;
      passes         = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_after_reset();
      test_key_extremes();
      test_random_traffic();
      test_health_failure();

      $display("Covered %0d samples, %0d blocks emitted, %0d rejected after failure",
               sent_count, emit_count, reject_count);
      $display("Four idling phases, cutoffs 2..512, key and seed extremes");
      if (error_count == 0) begin
         $display("tb_entropy_health_ghash_conditioner: done, clean");
      end else begin
         $display("tb_entropy_health_ghash_conditioner: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("tb_entropy_health_ghash_conditioner: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ehgc_pkg.sv
rtl/ehgc_stream_if.sv
rtl/ehgc_datapath.sv
rtl/ehgc_controller.sv
rtl/entropy_health_ghash_conditioner.sv
tb/sv/tb_entropy_health_ghash_conditioner.sv
